// ===== sv/slbm_pkg.sv =====
// Shared types, constants and brightness table for the status LED breathing manager.
package slbm_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int SINE_Q          = SINE_N / 4;

  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 10;
  localparam int PERIOD_W   = 11;
  localparam int BRIGHT_W   = 17;
  localparam int COLOR_W    = 8;
  localparam int DIV_W      = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(50);
  localparam logic [PERIOD_W-1:0]   AP_PERIOD_MS   = PERIOD_W'(2000);
  localparam logic [PERIOD_W-1:0]   CONN_PERIOD_MS = PERIOD_W'(1800);

  // floor(n / period) = ((n >> PRESHIFT) * RECIP) >> RECIP_SHIFT, exact for any 32-bit n
  // (2000 = 16 * 125, 1800 = 8 * 225)
  localparam int               AP_PRESHIFT      = 4;
  localparam int               AP_RECIP_SHIFT   = 35;
  localparam logic [DIV_W-1:0] AP_RECIP         = DIV_W'(274877907);
  localparam int               CONN_PRESHIFT    = 3;
  localparam int               CONN_RECIP_SHIFT = 37;
  localparam logic [DIV_W-1:0] CONN_RECIP       = DIV_W'(610839794);

  localparam logic [COLOR_W-1:0] AP_RED     = COLOR_W'(255);
  localparam logic [COLOR_W-1:0] AMBER_RED  = COLOR_W'(200);
  localparam logic [COLOR_W-1:0] AMBER_GRN  = COLOR_W'(140);
  localparam logic [COLOR_W-1:0] FIXED_GRN  = COLOR_W'(200);

  localparam logic [1:0] MODE_AP        = 2'd0;
  localparam logic [1:0] MODE_CONNECTING = 2'd1;
  localparam logic [1:0] MODE_CONNECTED = 2'd2;
  localparam logic [1:0] MODE_OFF       = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              ap_active;
    logic              wifi_connected;
    logic              have_saved_creds;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [1:0]         led_mode;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_PHASE,
    ST_DIV_INDEX,
    ST_LOOKUP,
    ST_MUL_RED,
    ST_MUL_GREEN,
    ST_EMIT
  } state_t;

  typedef logic [BRIGHT_W-1:0] bright_t;
  typedef bright_t bright_lut_t [SINE_N];

  // Brightness per sine index, Q16 in 13108..65536, from a Taylor sine per quadrant.
  function automatic bright_lut_t build_bright_lut();
    bright_lut_t lut;
    longint unsigned quad, r, u, x, x2, x3, x5, x7, x9, pos, neg, s, w, b;
    for (int i = 0; i < SINE_N; i++) begin
      quad = longint'(i) / SINE_Q;
      r    = longint'(i) % SINE_Q;
      u    = quad[0] ? (SINE_Q - r) : r;
      if (u == SINE_Q) begin
        s = 65536;
      end else begin
        x   = (u * 102944) / SINE_Q;
        x2  = (x * x) >> 16;
        x3  = (x * x2) >> 16;
        x5  = (x3 * x2) >> 16;
        x7  = (x5 * x2) >> 16;
        x9  = (x7 * x2) >> 16;
        pos = x + x5 / 120 + x9 / 362880;
        neg = x3 / 6 + x7 / 5040;
        s   = (pos > neg) ? pos - neg : 0;
        if (s > 65536) s = 65536;
      end
      w = (quad >= 2) ? 65536 - s : 65536 + s;
      b = 13108 + ((26214 * w + 32768) >> 16);
      if (b > 65536) b = 65536;
      lut[i] = BRIGHT_W'(b);
    end
    return lut;
  endfunction

  localparam bright_lut_t BRIGHT_LUT = build_bright_lut();

endpackage

// ===== sv/slbm_divu.sv =====
// Reciprocal divider for the two breath periods: quotient registered first, then the remainder.
module slbm_divu import slbm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quotient,
  output logic [PERIOD_W-1:0] remainder
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                step_r, step_nxt;
  logic                ap_r, ap_nxt;
  logic [DIV_W-1:0]    num_r, num_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]    mul_a;
  logic [DIV_W-1:0]    mul_b;
  logic [2*DIV_W-1:0]  prod;
  logic [PERIOD_W-1:0] diff;

  assign prod = mul_a * mul_b;
  // the remainder is below the period, so the low bits of the difference suffice
  assign diff = num_r[PERIOD_W-1:0] - prod[PERIOD_W-1:0];

  // shared multiplier: reciprocal scaling first, then quotient times period
  always_comb begin
    if (step_r) begin
      mul_a = quo_r;
      mul_b = DIV_W'(ap_r ? AP_PERIOD_MS : CONN_PERIOD_MS);
    end else if (ap_r) begin
      mul_a = num_r >> AP_PRESHIFT;
      mul_b = AP_RECIP;
    end else begin
      mul_a = num_r >> CONN_PRESHIFT;
      mul_b = CONN_RECIP;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    ap_nxt   = ap_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      ap_nxt   = (divisor == AP_PERIOD_MS);
      num_nxt  = dividend;
    end else if (busy_r) begin
      if (!step_r) begin
        // drop the fraction of the scaled dividend
        quo_nxt  = ap_r ? DIV_W'(prod[2*DIV_W-1:AP_RECIP_SHIFT])
                        : DIV_W'(prod[2*DIV_W-1:CONN_RECIP_SHIFT]);
        step_nxt = 1'b1;
      end else begin
        rem_nxt  = diff;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    ap_r  <= ap_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/status_led_breathing_manager.sv =====
// Top level of the status LED breathing manager: sequencer, state and output register.
//
//   channel | direction | payload       | handshake
//   in_     | input     | in_item_t     | in_valid / in_ready
//   out_    | output    | out_item_t    | out_valid / out_ready
//   cfg_    | input     | 10-bit interval | cfg_valid / cfg_ready
//
// A throttled item, or a connected item after green was sent, ends at the check.
// Off and fixed green go from the check to emit. A breath item runs the divider twice
// (phase within the period, then the sine index), then the lookup and both multiplies.
// Reset: interval 50 ms, last update time 0, green not shown, no result pending.
// A result waits in the output register; the next item is taken meanwhile and
// holds in the emit step only if the earlier result is still not taken.
module status_led_breathing_manager import slbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INTERVAL_W-1:0] cfg_data
);

  state_t                  state_r, state_nxt;
  in_item_t                item_r, item_nxt;
  logic [TIME_W-1:0]       last_r, last_nxt;
  logic [INTERVAL_W-1:0]   interval_r, interval_nxt;
  logic                    green_shown_r, green_shown_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [SINE_TABLE_BITS-1:0] idx_r, idx_nxt;
  bright_t                 bright_r, bright_nxt;
  logic [COLOR_W-1:0]      red_r, red_nxt;
  logic [COLOR_W-1:0]      green_r, green_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    throttled;
  logic                    breath;
  logic                    connecting;
  logic                    out_free;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [PERIOD_W-1:0]     div_divisor;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quo;
  logic [PERIOD_W-1:0]     div_rem;
  logic [COLOR_W-1:0]      mul_c;
  logic [COLOR_W+BRIGHT_W-1:0] mul_prod;

  assign throttled  = (item_r.time_ms - last_r) < TIME_W'(interval_r);
  assign connecting = !item_r.wifi_connected && item_r.have_saved_creds;
  assign breath     = item_r.ap_active || connecting;
  assign out_free   = !out_valid_r || out_ready;
  assign mul_prod   = mul_c * bright_r;

  slbm_divu u_divu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (throttled) begin
          state_nxt = ST_IDLE;
        end else if (breath) begin
          state_nxt = ST_DIV_PHASE;
        end else if (item_r.wifi_connected && green_shown_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV_PHASE: begin
        if (div_done) state_nxt = ST_DIV_INDEX;
      end
      ST_DIV_INDEX: begin
        if (div_done) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP:    state_nxt = ST_MUL_RED;
      ST_MUL_RED:   state_nxt = ST_MUL_GREEN;
      ST_MUL_GREEN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready        = 1'b0;
    div_start       = 1'b0;
    div_dividend    = DIV_W'(item_r.time_ms);
    div_divisor     = item_r.ap_active ? AP_PERIOD_MS : CONN_PERIOD_MS;
    mul_c           = (mode_r == MODE_AP) ? AP_RED : AMBER_RED;
    item_nxt        = item_r;
    last_nxt        = last_r;
    green_shown_nxt = green_shown_r;
    mode_nxt        = mode_r;
    idx_nxt         = idx_r;
    bright_nxt      = bright_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) item_nxt = in_data;
      end
      ST_CHECK: begin
        if (!throttled) begin
          last_nxt = item_r.time_ms;
          if (item_r.ap_active) begin
            mode_nxt        = MODE_AP;
            green_shown_nxt = 1'b0;
            div_start       = 1'b1;
          end else if (connecting) begin
            mode_nxt        = MODE_CONNECTING;
            green_shown_nxt = 1'b0;
            div_start       = 1'b1;
          end else if (item_r.wifi_connected) begin
            mode_nxt        = MODE_CONNECTED;
            green_shown_nxt = 1'b1;
            red_nxt         = '0;
            green_nxt       = FIXED_GRN;
          end else begin
            mode_nxt        = MODE_OFF;
            green_shown_nxt = 1'b0;
            red_nxt         = '0;
            green_nxt       = '0;
          end
        end
      end
      ST_DIV_PHASE: begin
        // scale the phase up and divide again for the sine index
        div_dividend = DIV_W'({div_rem, {SINE_TABLE_BITS{1'b0}}});
        div_start    = div_done;
      end
      ST_DIV_INDEX: begin
        if (div_done) idx_nxt = div_quo[SINE_TABLE_BITS-1:0];
      end
      ST_LOOKUP: begin
        bright_nxt = BRIGHT_LUT[idx_r];
      end
      ST_MUL_RED: begin
        red_nxt = mul_prod[16 +: COLOR_W];
      end
      ST_MUL_GREEN: begin
        mul_c     = AMBER_GRN;
        green_nxt = (mode_r == MODE_CONNECTING) ? mul_prod[16 +: COLOR_W] : '0;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.red      = red_r;
          out_data_nxt.green    = green_r;
          out_data_nxt.blue     = '0;
          out_data_nxt.led_mode = mode_r;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    if (cfg_valid) interval_nxt = cfg_data;
    else           interval_nxt = interval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_r        <= '0;
      interval_r    <= INTERVAL_RESET;
      green_shown_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_r        <= last_nxt;
      interval_r    <= interval_nxt;
      green_shown_r <= green_shown_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    mode_r     <= mode_nxt;
    idx_r      <= idx_nxt;
    bright_r   <= bright_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while one is in work");

  a_blue_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.blue == '0)
    else $error("blue channel driven");

  a_green_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.led_mode == MODE_CONNECTED |->
      out_data.red == '0 && out_data.green == FIXED_GRN)
    else $error("connected result is not fixed green");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.led_mode == MODE_OFF |->
      out_data.red == '0 && out_data.green == '0)
    else $error("off result is not dark");

  a_ap_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.led_mode == MODE_AP |->
      out_data.green == '0 && out_data.red >= COLOR_W'(51))
    else $error("red breath below brightness floor or green lit");

endmodule
